[hw/rtl/aff_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine fit package
// Shared widths, the solve request carried from front to back, and the
// solver's opcodes, register map and microcode table.
// ----------------------------------------------------------------------------
package aff_pkg;

	localparam int MAX_POINTS = 256;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int LOG_N      = $clog2(MAX_POINTS);
	localparam int SUM_X_W    = 16 + LOG_N;
	localparam int SUM_G_W    = 32 + LOG_N;
	localparam int PROD_W     = 32 + LOG_N;
	localparam int CROSS_W    = 48 + LOG_N;

	// Working width of the solver; every intermediate of the exact solve fits.
	localparam int BW         = 128 + 6 * CNT_W;
	localparam int FRAC_SHIFT = 18;
	localparam int COEF_W     = 64;
	localparam int NCOEF      = 6;
	localparam int QDEPTH     = 2;

	typedef struct packed {
		logic [CNT_W-1:0]          count;
		logic [SUM_X_W-1:0]        sum_x;
		logic [SUM_X_W-1:0]        sum_y;
		logic signed [SUM_G_W-1:0] sum_gx;
		logic signed [SUM_G_W-1:0] sum_gy;
		logic [PROD_W-1:0]         sum_xx;
		logic [PROD_W-1:0]         sum_yy;
		logic [PROD_W-1:0]         sum_xy;
		logic signed [CROSS_W-1:0] sum_xgx;
		logic signed [CROSS_W-1:0] sum_xgy;
		logic signed [CROSS_W-1:0] sum_ygx;
		logic signed [CROSS_W-1:0] sum_ygy;
		logic [15:0]               x0;
		logic [15:0]               y0;
		logic [15:0]               x1;
		logic [15:0]               y1;
		logic signed [31:0]        gx0;
		logic signed [31:0]        gy0;
		logic signed [31:0]        gx1;
		logic signed [31:0]        gy1;
	} solve_req_t;

	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_ZCHK = 3'd4;
	localparam logic [2:0] OP_ZERO = 3'd5;
	localparam logic [2:0] OP_DONE = 3'd6;

	localparam int RF_DEPTH = 37;
	localparam int RF_AW    = $clog2(RF_DEPTH);

	localparam logic [RF_AW-1:0] R_N    = 6'd0;
	localparam logic [RF_AW-1:0] R_SX   = 6'd1;
	localparam logic [RF_AW-1:0] R_SY   = 6'd2;
	localparam logic [RF_AW-1:0] R_SGX  = 6'd3;
	localparam logic [RF_AW-1:0] R_SGY  = 6'd4;
	localparam logic [RF_AW-1:0] R_SXX  = 6'd5;
	localparam logic [RF_AW-1:0] R_SYY  = 6'd6;
	localparam logic [RF_AW-1:0] R_SXY  = 6'd7;
	localparam logic [RF_AW-1:0] R_CXGX = 6'd8;
	localparam logic [RF_AW-1:0] R_CXGY = 6'd9;
	localparam logic [RF_AW-1:0] R_CYGX = 6'd10;
	localparam logic [RF_AW-1:0] R_CYGY = 6'd11;
	localparam logic [RF_AW-1:0] R_X0   = 6'd12;
	localparam logic [RF_AW-1:0] R_Y0   = 6'd13;
	localparam logic [RF_AW-1:0] R_X1   = 6'd14;
	localparam logic [RF_AW-1:0] R_Y1   = 6'd15;
	localparam logic [RF_AW-1:0] R_GX0  = 6'd16;
	localparam logic [RF_AW-1:0] R_GY0  = 6'd17;
	localparam logic [RF_AW-1:0] R_GX1  = 6'd18;
	localparam logic [RF_AW-1:0] R_GY1  = 6'd19;
	localparam logic [RF_AW-1:0] R_T0   = 6'd20;
	localparam logic [RF_AW-1:0] R_T1   = 6'd21;
	localparam logic [RF_AW-1:0] R_A    = 6'd22;
	localparam logic [RF_AW-1:0] R_B    = 6'd23;
	localparam logic [RF_AW-1:0] R_C    = 6'd24;
	localparam logic [RF_AW-1:0] R_PXX  = 6'd25;
	localparam logic [RF_AW-1:0] R_PXY  = 6'd26;
	localparam logic [RF_AW-1:0] R_PYX  = 6'd27;
	localparam logic [RF_AW-1:0] R_PYY  = 6'd28;
	localparam logic [RF_AW-1:0] R_D    = 6'd29;
	localparam logic [RF_AW-1:0] R_NXX  = 6'd30;
	localparam logic [RF_AW-1:0] R_NXY  = 6'd31;
	localparam logic [RF_AW-1:0] R_NYX  = 6'd32;
	localparam logic [RF_AW-1:0] R_NYY  = 6'd33;
	localparam logic [RF_AW-1:0] R_ND   = 6'd34;
	localparam logic [RF_AW-1:0] R_OX   = 6'd35;
	localparam logic [RF_AW-1:0] R_OY   = 6'd36;

	// The two-point program reuses some registers of the full solve.
	localparam logic [RF_AW-1:0] R_DX   = R_A;
	localparam logic [RF_AW-1:0] R_DY   = R_B;
	localparam logic [RF_AW-1:0] R_DGX  = R_C;
	localparam logic [RF_AW-1:0] R_DGY  = R_PXX;

	localparam logic [RF_AW-1:0] C_OX = 6'd0;
	localparam logic [RF_AW-1:0] C_XX = 6'd1;
	localparam logic [RF_AW-1:0] C_XY = 6'd2;
	localparam logic [RF_AW-1:0] C_OY = 6'd3;
	localparam logic [RF_AW-1:0] C_YX = 6'd4;
	localparam logic [RF_AW-1:0] C_YY = 6'd5;

	typedef struct packed {
		logic [2:0]       op;
		logic [RF_AW-1:0] dst;
		logic [RF_AW-1:0] ra;
		logic [RF_AW-1:0] rb;
	} uop_t;

	localparam int UC_DEPTH = 96;
	localparam int PC_W     = $clog2(UC_DEPTH);
	localparam logic [PC_W-1:0] PC_TWO  = 7'd0;
	localparam logic [PC_W-1:0] PC_MANY = 7'd27;

	localparam uop_t UCODE [UC_DEPTH] = '{
		// two points: scale and offset only
		'{OP_LOAD, R_X0,  R_N,   R_N},
		'{OP_LOAD, R_Y0,  R_N,   R_N},
		'{OP_LOAD, R_X1,  R_N,   R_N},
		'{OP_LOAD, R_Y1,  R_N,   R_N},
		'{OP_LOAD, R_GX0, R_N,   R_N},
		'{OP_LOAD, R_GY0, R_N,   R_N},
		'{OP_LOAD, R_GX1, R_N,   R_N},
		'{OP_LOAD, R_GY1, R_N,   R_N},
		'{OP_SUB,  R_DX,  R_X1,  R_X0},
		'{OP_SUB,  R_DY,  R_Y1,  R_Y0},
		'{OP_ZCHK, R_N,   R_DX,  R_N},
		'{OP_ZCHK, R_N,   R_DY,  R_N},
		'{OP_SUB,  R_DGX, R_GX1, R_GX0},
		'{OP_SUB,  R_DGY, R_GY1, R_GY0},
		'{OP_DIV,  C_XX,  R_DGX, R_DX},
		'{OP_MUL,  R_T0,  R_GX0, R_DX},
		'{OP_MUL,  R_T1,  R_X0,  R_DGX},
		'{OP_SUB,  R_T0,  R_T0,  R_T1},
		'{OP_DIV,  C_OX,  R_T0,  R_DX},
		'{OP_DIV,  C_YY,  R_DGY, R_DY},
		'{OP_MUL,  R_T0,  R_GY0, R_DY},
		'{OP_MUL,  R_T1,  R_Y0,  R_DGY},
		'{OP_SUB,  R_T0,  R_T0,  R_T1},
		'{OP_DIV,  C_OY,  R_T0,  R_DY},
		'{OP_ZERO, C_XY,  R_N,   R_N},
		'{OP_ZERO, C_YX,  R_N,   R_N},
		'{OP_DONE, R_N,   R_N,   R_N},
		// more than two points: centred normal equations
		'{OP_LOAD, R_N,    R_N,   R_N},
		'{OP_LOAD, R_SX,   R_N,   R_N},
		'{OP_LOAD, R_SY,   R_N,   R_N},
		'{OP_LOAD, R_SGX,  R_N,   R_N},
		'{OP_LOAD, R_SGY,  R_N,   R_N},
		'{OP_LOAD, R_SXX,  R_N,   R_N},
		'{OP_LOAD, R_SYY,  R_N,   R_N},
		'{OP_LOAD, R_SXY,  R_N,   R_N},
		'{OP_LOAD, R_CXGX, R_N,   R_N},
		'{OP_LOAD, R_CXGY, R_N,   R_N},
		'{OP_LOAD, R_CYGX, R_N,   R_N},
		'{OP_LOAD, R_CYGY, R_N,   R_N},
		'{OP_MUL,  R_T0,  R_N,   R_SXX},
		'{OP_MUL,  R_T1,  R_SX,  R_SX},
		'{OP_SUB,  R_A,   R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_N,   R_SYY},
		'{OP_MUL,  R_T1,  R_SY,  R_SY},
		'{OP_SUB,  R_B,   R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_N,   R_SXY},
		'{OP_MUL,  R_T1,  R_SX,  R_SY},
		'{OP_SUB,  R_C,   R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_N,   R_CXGX},
		'{OP_MUL,  R_T1,  R_SX,  R_SGX},
		'{OP_SUB,  R_PXX, R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_N,   R_CXGY},
		'{OP_MUL,  R_T1,  R_SX,  R_SGY},
		'{OP_SUB,  R_PXY, R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_N,   R_CYGX},
		'{OP_MUL,  R_T1,  R_SY,  R_SGX},
		'{OP_SUB,  R_PYX, R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_N,   R_CYGY},
		'{OP_MUL,  R_T1,  R_SY,  R_SGY},
		'{OP_SUB,  R_PYY, R_T0,  R_T1},
		'{OP_ZCHK, R_N,   R_A,   R_N},
		'{OP_ZCHK, R_N,   R_B,   R_N},
		'{OP_MUL,  R_T0,  R_A,   R_B},
		'{OP_MUL,  R_T1,  R_C,   R_C},
		'{OP_SUB,  R_D,   R_T0,  R_T1},
		'{OP_ZCHK, R_N,   R_D,   R_N},
		'{OP_MUL,  R_T0,  R_PXX, R_B},
		'{OP_MUL,  R_T1,  R_PYX, R_C},
		'{OP_SUB,  R_NXX, R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_PYX, R_A},
		'{OP_MUL,  R_T1,  R_PXX, R_C},
		'{OP_SUB,  R_NXY, R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_PXY, R_B},
		'{OP_MUL,  R_T1,  R_PYY, R_C},
		'{OP_SUB,  R_NYX, R_T0,  R_T1},
		'{OP_MUL,  R_T0,  R_PYY, R_A},
		'{OP_MUL,  R_T1,  R_PXY, R_C},
		'{OP_SUB,  R_NYY, R_T0,  R_T1},
		'{OP_MUL,  R_ND,  R_N,   R_D},
		'{OP_MUL,  R_T0,  R_SGX, R_D},
		'{OP_MUL,  R_T1,  R_SX,  R_NXX},
		'{OP_SUB,  R_OX,  R_T0,  R_T1},
		'{OP_MUL,  R_T1,  R_SY,  R_NXY},
		'{OP_SUB,  R_OX,  R_OX,  R_T1},
		'{OP_MUL,  R_T0,  R_SGY, R_D},
		'{OP_MUL,  R_T1,  R_SX,  R_NYX},
		'{OP_SUB,  R_OY,  R_T0,  R_T1},
		'{OP_MUL,  R_T1,  R_SY,  R_NYY},
		'{OP_SUB,  R_OY,  R_OY,  R_T1},
		'{OP_DIV,  C_OX,  R_OX,  R_ND},
		'{OP_DIV,  C_XX,  R_NXX, R_D},
		'{OP_DIV,  C_XY,  R_NXY, R_D},
		'{OP_DIV,  C_OY,  R_OY,  R_ND},
		'{OP_DIV,  C_YX,  R_NYX, R_D},
		'{OP_DIV,  C_YY,  R_NYY, R_D},
		'{OP_DONE, R_N,   R_N,   R_N}
	};

endpackage

[hw/rtl/affine_fit_from_control_points.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine fit from control points
// Least-squares affine transform from calibration points, in exact integers.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while the input is ready; the point that closes
// a set stalls the input until its sums have moved into a two-entry request
// queue, which takes longer while that queue is full.
// The run time of a fit over more than two points is set by the bit-serial
// multiplier and the restoring divider (BW = 182).
// A two-point fit runs a shorter program; a failing set stops early.
// Reset clears the sums, the queue, the output register and the transform.
module affine_fit_from_control_points (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        map_x,
	input  logic [15:0]        map_y,
	input  logic signed [31:0] geo_x,
	input  logic signed [31:0] geo_y,
	input  logic               point_valid,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] offset_x,
	output logic signed [63:0] gain_xx,
	output logic signed [63:0] gain_xy,
	output logic signed [63:0] offset_y,
	output logic signed [63:0] gain_yx,
	output logic signed [63:0] gain_yy,
	output logic               fit_ok,
	output logic               saturated
);
	import aff_pkg::*;

	solve_req_t push_req, pop_req;
	logic       push_valid, push_ready, pop_valid, pop_ready;
	logic [63:0] ox, gxx, gxy, oy, gyx, gyy;

	aff_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.map_x       (map_x),
		.map_y       (map_y),
		.geo_x       (geo_x),
		.geo_y       (geo_y),
		.point_valid (point_valid),
		.last        (last),
		.req_valid   (push_valid),
		.req_ready   (push_ready),
		.req         (push_req)
	);

	aff_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_req),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_req)
	);

	aff_solve u_solve (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (pop_valid),
		.req_ready (pop_ready),
		.req       (pop_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.offset_x  (ox),
		.gain_xx   (gxx),
		.gain_xy   (gxy),
		.offset_y  (oy),
		.gain_yx   (gyx),
		.gain_yy   (gyy),
		.fit_ok    (fit_ok),
		.saturated (saturated)
	);

	assign offset_x = $signed(ox);
	assign gain_xx  = $signed(gxx);
	assign gain_xy  = $signed(gxy);
	assign offset_y = $signed(oy);
	assign gain_yx  = $signed(gyx);
	assign gain_yy  = $signed(gyy);

endmodule

[hw/rtl/aff_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine fit front end
// Accepts calibration points, keeps exact sums and the first two valid
// points, and hands a solve request to the queue when a set closes.
// ----------------------------------------------------------------------------
module aff_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        map_x,
	input  logic [15:0]        map_y,
	input  logic signed [31:0] geo_x,
	input  logic signed [31:0] geo_y,
	input  logic               point_valid,
	input  logic               last,
	output logic               req_valid,
	input  logic               req_ready,
	output aff_pkg::solve_req_t req
);
	import aff_pkg::*;

	logic [CNT_W-1:0]          count_q;
	logic [SUM_X_W-1:0]        sx_q, sy_q;
	logic signed [SUM_G_W-1:0] sgx_q, sgy_q;
	logic [PROD_W-1:0]         sxx_q, syy_q, sxy_q;
	logic signed [CROSS_W-1:0] cxgx_q, cxgy_q, cygx_q, cygy_q;
	logic [15:0]               x0_q, y0_q, x1_q, y1_q;
	logic signed [31:0]        gx0_q, gy0_q, gx1_q, gy1_q;
	logic                      pend_q;

	logic                      accept, take, push;
	logic [31:0]               pxx, pyy, pxy;
	logic signed [48:0]        pxgx, pxgy, pygx, pygy;

	assign in_ready  = !pend_q;
	assign req_valid = pend_q;
	assign accept    = in_valid && in_ready;
	assign take      = accept && point_valid && (count_q < CNT_W'(MAX_POINTS));
	assign push      = pend_q && req_ready;

	assign pxx  = map_x * map_x;
	assign pyy  = map_y * map_y;
	assign pxy  = map_x * map_y;
	assign pxgx = $signed({1'b0, map_x}) * geo_x;
	assign pxgy = $signed({1'b0, map_x}) * geo_y;
	assign pygx = $signed({1'b0, map_y}) * geo_x;
	assign pygy = $signed({1'b0, map_y}) * geo_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sgx_q   <= '0;
			sgy_q   <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			cxgx_q  <= '0;
			cxgy_q  <= '0;
			cygx_q  <= '0;
			cygy_q  <= '0;
			pend_q  <= 1'b0;
		end else if (push) begin
			// The set has been handed over; start the next one from zero.
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sgx_q   <= '0;
			sgy_q   <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
			cxgx_q  <= '0;
			cxgy_q  <= '0;
			cygx_q  <= '0;
			cygy_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (take) begin
				count_q <= count_q + 1'b1;
				sx_q    <= sx_q + SUM_X_W'(map_x);
				sy_q    <= sy_q + SUM_X_W'(map_y);
				sgx_q   <= sgx_q + SUM_G_W'(geo_x);
				sgy_q   <= sgy_q + SUM_G_W'(geo_y);
				sxx_q   <= sxx_q + PROD_W'(pxx);
				syy_q   <= syy_q + PROD_W'(pyy);
				sxy_q   <= sxy_q + PROD_W'(pxy);
				cxgx_q  <= cxgx_q + CROSS_W'(pxgx);
				cxgy_q  <= cxgy_q + CROSS_W'(pxgy);
				cygx_q  <= cygx_q + CROSS_W'(pygx);
				cygy_q  <= cygy_q + CROSS_W'(pygy);
			end
			if (accept && last) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && count_q == '0) begin
			x0_q  <= map_x;
			y0_q  <= map_y;
			gx0_q <= geo_x;
			gy0_q <= geo_y;
		end
		if (take && count_q == CNT_W'(1)) begin
			x1_q  <= map_x;
			y1_q  <= map_y;
			gx1_q <= geo_x;
			gy1_q <= geo_y;
		end
	end

	always_comb begin
		req.count   = count_q;
		req.sum_x   = sx_q;
		req.sum_y   = sy_q;
		req.sum_gx  = sgx_q;
		req.sum_gy  = sgy_q;
		req.sum_xx  = sxx_q;
		req.sum_yy  = syy_q;
		req.sum_xy  = sxy_q;
		req.sum_xgx = cxgx_q;
		req.sum_xgy = cxgy_q;
		req.sum_ygx = cygx_q;
		req.sum_ygy = cygy_q;
		req.x0      = x0_q;
		req.y0      = y0_q;
		req.x1      = x1_q;
		req.y1      = y1_q;
		req.gx0     = gx0_q;
		req.gy0     = gy0_q;
		req.gx1     = gx1_q;
		req.gy1     = gy1_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond its limit");

	a_clear_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (count_q == '0 && sx_q == '0 && sxx_q == '0))
		else $error("set not cleared after hand-over");

	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (pend_q && !in_ready))
		else $error("closed set did not stall the input");

endmodule

[hw/rtl/aff_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine fit request queue
// Two-entry queue of solve requests between the front end and the solver.
// ----------------------------------------------------------------------------
module aff_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  aff_pkg::solve_req_t push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output aff_pkg::solve_req_t pop_data
);
	import aff_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	solve_req_t          mem_q [QDEPTH];
	logic [PW-1:0]       wr_q, rd_q;
	logic [PW:0]         cnt_q;
	logic                push, pop;

	assign push_ready = cnt_q != (PW+1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QDEPTH))
		else $error("queue fill beyond depth");

	a_pop_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue fill not reduced by a pop");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == (PW+1)'(QDEPTH)) |-> wr_q == rd_q)
		else $error("queue pointers disagree with fill");

endmodule

[hw/rtl/aff_solve.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine fit solver
// Microcoded exact integer solver: a register file, a shift-add multiplier
// and a restoring divider that rounds and saturates each coefficient.
// ----------------------------------------------------------------------------
module aff_solve (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  aff_pkg::solve_req_t req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         offset_x,
	output logic [63:0]         gain_xx,
	output logic [63:0]         gain_xy,
	output logic [63:0]         offset_y,
	output logic [63:0]         gain_yx,
	output logic [63:0]         gain_yy,
	output logic                fit_ok,
	output logic                saturated
);
	import aff_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	localparam int DCW = $clog2(BW + 1);

	logic [2:0]               st_q;
	logic [PC_W-1:0]          pc_q;
	uop_t                     uop;

	logic signed [BW-1:0]     rf_q [RF_DEPTH];
	logic signed [BW-1:0]     opa_s1, opb_s1;
	logic                     rf_we;
	logic signed [BW-1:0]     rf_wd, load_val;

	logic [BW-1:0]            abs_a, abs_b;
	logic [BW-1:0]            mc_q, mp_q, acc_q;
	logic                     mneg_q;

	logic [BW-1:0]            dn_q, dd_q, dq_q;
	logic [BW:0]              dr_q, dr_try;
	logic                     dneg_q;
	logic [DCW-1:0]           dcnt_q;
	logic                     d_ge;
	logic                     q_big, q_over;
	logic [COEF_W-1:0]        q_lim, q_sat, q_res;

	logic [COEF_W-1:0]        coef_q [NCOEF];
	logic [COEF_W-1:0]        transform_q [NCOEF];
	logic                     ok_q, sat_q;
	logic                     out_valid_q, out_ok_q, out_sat_q;
	logic                     load_out;

	assign uop      = UCODE[pc_q];
	assign abs_a    = opa_s1[BW-1] ? BW'(-opa_s1) : BW'(opa_s1);
	assign abs_b    = opb_s1[BW-1] ? BW'(-opb_s1) : BW'(opb_s1);
	assign load_out = (st_q == ST_OUT) && (!out_valid_q || out_ready);
	assign req_ready = load_out;

	always_comb begin
		case (uop.dst)
			R_N:     load_val = BW'(req.count);
			R_SX:    load_val = BW'(req.sum_x);
			R_SY:    load_val = BW'(req.sum_y);
			R_SGX:   load_val = BW'(req.sum_gx);
			R_SGY:   load_val = BW'(req.sum_gy);
			R_SXX:   load_val = BW'(req.sum_xx);
			R_SYY:   load_val = BW'(req.sum_yy);
			R_SXY:   load_val = BW'(req.sum_xy);
			R_CXGX:  load_val = BW'(req.sum_xgx);
			R_CXGY:  load_val = BW'(req.sum_xgy);
			R_CYGX:  load_val = BW'(req.sum_ygx);
			R_CYGY:  load_val = BW'(req.sum_ygy);
			R_X0:    load_val = BW'(req.x0);
			R_Y0:    load_val = BW'(req.y0);
			R_X1:    load_val = BW'(req.x1);
			R_Y1:    load_val = BW'(req.y1);
			R_GX0:   load_val = BW'(req.gx0);
			R_GY0:   load_val = BW'(req.gy0);
			R_GX1:   load_val = BW'(req.gx1);
			R_GY1:   load_val = BW'(req.gy1);
			default: load_val = '0;
		endcase
	end

	always_comb begin
		rf_we = 1'b0;
		rf_wd = load_val;
		if (st_q == ST_EXEC && uop.op == OP_LOAD) begin
			rf_we = 1'b1;
		end else if (st_q == ST_EXEC && uop.op == OP_SUB) begin
			rf_we = 1'b1;
			rf_wd = opa_s1 - opb_s1;
		end else if (st_q == ST_MUL && mp_q == '0) begin
			rf_we = 1'b1;
			rf_wd = mneg_q ? $signed(-acc_q) : $signed(acc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[uop.dst] <= rf_wd;
		end
		if (st_q == ST_READ) begin
			opa_s1 <= rf_q[uop.ra];
			opb_s1 <= rf_q[uop.rb];
		end
	end

	// One restoring step: bring down the next numerator bit and subtract.
	assign dr_try = {dr_q[BW-1:0], dn_q[BW-1]};
	assign d_ge   = dr_try >= {1'b0, dd_q};

	// Quotient is the rounded magnitude; clamp it to the signed 64-bit range.
	assign q_big  = |dq_q[BW-1:COEF_W];
	assign q_lim  = dneg_q ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
	assign q_over = q_big || (dq_q[COEF_W-1:0] > q_lim);
	assign q_sat  = q_over ? q_lim : dq_q[COEF_W-1:0];
	assign q_res  = dneg_q ? COEF_W'(-q_sat) : q_sat;

	always_ff @(posedge clk) begin
		if (st_q == ST_EXEC && uop.op == OP_MUL) begin
			mc_q   <= abs_a;
			mp_q   <= abs_b;
			acc_q  <= '0;
			mneg_q <= opa_s1[BW-1] ^ opb_s1[BW-1];
		end else if (st_q == ST_MUL && mp_q != '0) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
		if (st_q == ST_EXEC && uop.op == OP_DIV) begin
			dn_q   <= (abs_a << (FRAC_SHIFT + 1)) + abs_b;
			dd_q   <= abs_b << 1;
			dr_q   <= '0;
			dq_q   <= '0;
			dneg_q <= opa_s1[BW-1] ^ opb_s1[BW-1];
		end else if (st_q == ST_DIV && dcnt_q != DCW'(BW)) begin
			dn_q <= dn_q << 1;
			dr_q <= d_ge ? dr_try - {1'b0, dd_q} : dr_try;
			dq_q <= {dq_q[BW-2:0], d_ge};
		end
		if (st_q == ST_EXEC && uop.op == OP_ZERO) begin
			coef_q[uop.dst[2:0]] <= '0;
		end else if (st_q == ST_DIV && dcnt_q == DCW'(BW)) begin
			coef_q[uop.dst[2:0]] <= q_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pc_q        <= '0;
			dcnt_q      <= '0;
			ok_q        <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_ok_q    <= 1'b0;
			out_sat_q   <= 1'b0;
			for (int i = 0; i < NCOEF; i++) begin
				transform_q[i] <= '0;
			end
		end else begin
			// A new result loaded in the same cycle keeps the output valid.
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						ok_q  <= 1'b0;
						sat_q <= 1'b0;
						if (req.count > CNT_W'(2)) begin
							pc_q <= PC_MANY;
							st_q <= ST_READ;
						end else if (req.count == CNT_W'(2)) begin
							pc_q <= PC_TWO;
							st_q <= ST_READ;
						end else begin
							st_q <= ST_OUT;
						end
					end
				end
				ST_READ: begin
					st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					unique case (uop.op)
						OP_MUL: begin
							st_q <= ST_MUL;
						end
						OP_DIV: begin
							dcnt_q <= '0;
							st_q   <= ST_DIV;
						end
						OP_ZCHK: begin
							if (opa_s1 == '0) begin
								st_q <= ST_OUT;
							end else begin
								pc_q <= pc_q + 1'b1;
								st_q <= ST_READ;
							end
						end
						OP_DONE: begin
							ok_q <= 1'b1;
							st_q <= ST_OUT;
						end
						OP_LOAD, OP_SUB, OP_ZERO: begin
							pc_q <= pc_q + 1'b1;
							st_q <= ST_READ;
						end
						default: begin
							st_q <= ST_OUT;
						end
					endcase
				end
				ST_MUL: begin
					if (mp_q == '0) begin
						pc_q <= pc_q + 1'b1;
						st_q <= ST_READ;
					end
				end
				ST_DIV: begin
					if (dcnt_q == DCW'(BW)) begin
						sat_q <= sat_q | q_over;
						pc_q  <= pc_q + 1'b1;
						st_q  <= ST_READ;
					end else begin
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						if (ok_q) begin
							for (int i = 0; i < NCOEF; i++) begin
								transform_q[i] <= coef_q[i];
							end
						end
						out_ok_q    <= ok_q;
						out_sat_q   <= ok_q & sat_q;
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign fit_ok    = out_ok_q;
	assign saturated = out_sat_q;
	assign offset_x  = transform_q[0];
	assign gain_xx   = transform_q[1];
	assign gain_xy   = transform_q[2];
	assign offset_y  = transform_q[3];
	assign gain_yx   = transform_q[4];
	assign gain_yy   = transform_q[5];

	a_busy_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> req_valid)
		else $error("solver busy without a queued request");

	a_sat_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ok_q) |-> !out_sat_q)
		else $error("saturation flagged on a failed fit");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_OUT))
		else $error("result raised outside the output step");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !ok_q) |=> (transform_q[0] == $past(transform_q[0])
			&& transform_q[5] == $past(transform_q[5])))
		else $error("failed fit changed the transform");

endmodule
